// ===== rtl/tccs_pkg.sv =====
// Package for the text console engine: geometry constants, character codes,
// payload structs, controller states, datapath commands and status.
// No dependencies; the controller, datapath, top level and testbench import it.
package tccs_pkg;

  localparam int MAX_COLUMNS = 80;
  localparam int ROWS_LIMIT  = 25;
  localparam int STORE_DEPTH = MAX_COLUMNS * ROWS_LIMIT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH + 1);

  localparam int OP_W     = 2;
  localparam int CHAR_W   = 8;
  localparam int ATTR_W   = 8;
  localparam int COL_W    = 7;
  localparam int ROW_W    = 5;
  localparam int LIN_W    = 11;
  localparam int CELL_W   = 16;
  // Widest linear index the raw inputs can form: max row * columns + max column.
  localparam int IDX_W    = $clog2((2**ROW_W - 1) * MAX_COLUMNS + 2**COL_W);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [COL_W-1:0]  MAX_COLS_C   = COL_W'(MAX_COLUMNS);
  localparam logic [ROW_W-1:0]  ROWS_LIMIT_C = ROW_W'(ROWS_LIMIT);
  localparam logic [ROW_W-1:0]  MIN_ROWS_C   = ROW_W'(2);
  localparam logic [COL_W-1:0]  MIN_COLS_C   = COL_W'(1);
  localparam logic [COL_W-1:0]  RST_COLS_C   = COL_W'(80);
  localparam logic [ROW_W-1:0]  RST_ROWS_C   = ROW_W'(25);

  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CH_ERASE   = 8'd14;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;
  localparam logic [CELL_W-1:0] CLEAR_CELL = 16'h0700;

  typedef enum logic [OP_W-1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_SET   = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLOR   = 2'd0,
    CFG_COLUMNS = 2'd1,
    CFG_ROWS    = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [CHAR_W-1:0] char_code;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
  } tccs_in_t;

  typedef struct packed {
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic [LIN_W-1:0]  cursor_linear;
    logic [CELL_W-1:0] cell_value;
  } tccs_out_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_ERASE,
    ST_CALC,
    ST_WRITE,
    ST_ADVANCE,
    ST_NEWLINE,
    ST_NL_CHECK,
    ST_SCROLL_RD,
    ST_SCROLL_WR,
    ST_SCROLL_ZERO,
    ST_LINE_DEC,
    ST_CLEAR,
    ST_SET,
    ST_READ,
    ST_DONE
  } state_t;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_INIT_STEP,
    CMD_LATCH,
    CMD_ERASE_BACK,
    CMD_CALC_IDX,
    CMD_WRITE_CHAR,
    CMD_ADVANCE,
    CMD_NEWLINE,
    CMD_PTR_CLR,
    CMD_SCROLL_RD,
    CMD_SCROLL_WR,
    CMD_ZERO_STEP,
    CMD_LINE_DEC,
    CMD_CLEAR_STEP,
    CMD_SET_CURSOR,
    CMD_READ,
    CMD_RESULT
  } cmd_t;

  typedef struct packed {
    op_t  in_op;        // operation of the word offered at the input
    logic in_newline;
    logic in_erase;
    op_t  item_op;      // operation of the word being worked on
    logic item_erase;
    logic col_wrap;     // advancing the cursor reaches the row width
    logic scroll_need;  // cursor line at or below the last usable line
    logic copy_done;    // scroll copy pointer reached the last row
    logic fill_last;    // sweep pointer on the last cell of the screen
    logic init_last;    // sweep pointer on the last cell of the store
  } tccs_status_t;

endpackage

// ===== rtl/tccs_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Standalone; no package dependencies.
module tccs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/tccs_ctrl.sv =====
// Controller state machine of the text console engine: sequences the
// datapath through writes, scrolls, clears and reads. Uses tccs_pkg.
module tccs_ctrl
  import tccs_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  tccs_status_t st,
  output cmd_t         cmd,
  output logic         busy
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE) || !rst_n;

  always_comb begin
    state_nxt = state_r;
    cmd       = CMD_NONE;
    unique case (state_r)
      ST_INIT: begin
        cmd = CMD_INIT_STEP;
        if (st.init_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          cmd = CMD_LATCH;
          unique case (st.in_op)
            OP_PUT: begin
              if (st.in_newline)    state_nxt = ST_NEWLINE;
              else if (st.in_erase) state_nxt = ST_ERASE;
              else                  state_nxt = ST_CALC;
            end
            OP_CLEAR: state_nxt = ST_CLEAR;
            OP_SET:   state_nxt = ST_SET;
            OP_READ:  state_nxt = ST_CALC;
            default:  state_nxt = ST_CALC;
          endcase
        end
      end
      ST_ERASE: begin
        cmd       = CMD_ERASE_BACK;
        state_nxt = ST_CALC;
      end
      ST_CALC: begin
        cmd       = CMD_CALC_IDX;
        state_nxt = (st.item_op == OP_READ) ? ST_READ : ST_WRITE;
      end
      ST_WRITE: begin
        cmd       = CMD_WRITE_CHAR;
        state_nxt = st.item_erase ? ST_DONE : ST_ADVANCE;
      end
      ST_ADVANCE: begin
        cmd       = CMD_ADVANCE;
        state_nxt = st.col_wrap ? ST_NEWLINE : ST_DONE;
      end
      ST_NEWLINE: begin
        cmd       = CMD_NEWLINE;
        state_nxt = ST_NL_CHECK;
      end
      ST_NL_CHECK: begin
        if (st.scroll_need) begin
          cmd       = CMD_PTR_CLR;
          state_nxt = ST_SCROLL_RD;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_SCROLL_RD: begin
        if (st.copy_done) begin
          state_nxt = ST_SCROLL_ZERO;
        end else begin
          cmd       = CMD_SCROLL_RD;
          state_nxt = ST_SCROLL_WR;
        end
      end
      ST_SCROLL_WR: begin
        cmd       = CMD_SCROLL_WR;
        state_nxt = ST_SCROLL_RD;
      end
      ST_SCROLL_ZERO: begin
        cmd = CMD_ZERO_STEP;
        if (st.fill_last) state_nxt = ST_LINE_DEC;
      end
      ST_LINE_DEC: begin
        // One row scrolled; the check repeats until the line is above the last row.
        cmd       = CMD_LINE_DEC;
        state_nxt = ST_NL_CHECK;
      end
      ST_CLEAR: begin
        cmd = CMD_CLEAR_STEP;
        if (st.fill_last) state_nxt = ST_DONE;
      end
      ST_SET: begin
        cmd       = CMD_SET_CURSOR;
        state_nxt = ST_DONE;
      end
      ST_READ: begin
        cmd       = CMD_READ;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        cmd       = CMD_RESULT;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/tccs_dp.sv =====
// Datapath of the text console engine: configuration registers, cursor,
// sweep pointer, cell store and result register. Uses tccs_pkg and tccs_ram.
module tccs_dp
  import tccs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output tccs_status_t          st,
  input  tccs_in_t              in_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic                  out_valid,
  output tccs_out_t             out_data
);

  logic [ATTR_W-1:0] attr_r;
  logic [COL_W-1:0]  cols_r;
  logic [ROW_W-1:0]  rows_r;

  logic [COL_W-1:0]  cur_col_r, cur_col_nxt;
  logic [ROW_W-1:0]  cur_row_r, cur_row_nxt;
  logic [ADDR_W-1:0] ptr_r, ptr_nxt;
  logic              read_ok_r, read_ok_nxt;
  logic              out_valid_r;

  op_t               op_r;
  logic [CHAR_W-1:0] ch_r;
  logic [COL_W-1:0]  col_r;
  logic [ROW_W-1:0]  row_r;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [ADDR_W-1:0] total_r;
  tccs_out_t         out_r, out_nxt;

  logic [COL_W-1:0]  eff_cols;
  logic [ROW_W-1:0]  eff_rows;
  logic [ADDR_W-1:0] last_row_base;
  logic [COL_W-1:0]  col_src;
  logic              in_range;
  logic              item_erase;

  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;

  // Geometry is clamped to the usable range wherever it is used.
  always_comb begin
    if (cols_r < MIN_COLS_C)        eff_cols = MIN_COLS_C;
    else if (cols_r > MAX_COLS_C)   eff_cols = MAX_COLS_C;
    else                            eff_cols = cols_r;
    if (rows_r < MIN_ROWS_C)        eff_rows = MIN_ROWS_C;
    else if (rows_r > ROWS_LIMIT_C) eff_rows = ROWS_LIMIT_C;
    else                            eff_rows = rows_r;
  end

  assign last_row_base = total_r - ADDR_W'(eff_cols);
  assign in_range      = idx_r < IDX_W'(total_r);
  assign item_erase    = (op_r == OP_PUT) && (ch_r == CH_ERASE);
  assign col_src       = item_erase ? cur_col_r : col_r;

  always_comb begin
    st.in_op       = op_t'(in_data.operation);
    st.in_newline  = in_data.char_code == CH_NEWLINE;
    st.in_erase    = in_data.char_code == CH_ERASE;
    st.item_op     = op_r;
    st.item_erase  = item_erase;
    st.col_wrap    = ({1'b0, cur_col_r} + (COL_W+1)'(1)) >= {1'b0, eff_cols};
    st.scroll_need = cur_row_r >= (eff_rows - ROW_W'(1));
    st.copy_done   = ptr_r == last_row_base;
    st.fill_last   = ptr_r == (total_r - ADDR_W'(1));
    st.init_last   = ptr_r == ADDR_W'(STORE_DEPTH - 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= '0;
      cols_r <= RST_COLS_C;
      rows_r <= RST_ROWS_C;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_COLOR:   attr_r <= ATTR_W'(cfg_wdata);
        CFG_COLUMNS: cols_r <= cfg_wdata[COL_W-1:0];
        CFG_ROWS:    rows_r <= cfg_wdata[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cur_col_nxt = cur_col_r;
    cur_row_nxt = cur_row_r;
    ptr_nxt     = ptr_r;
    read_ok_nxt = read_ok_r;
    idx_nxt     = idx_r;
    out_nxt     = out_r;
    ram_we      = 1'b0;
    ram_waddr   = ptr_r;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = ptr_r + ADDR_W'(eff_cols);
    unique case (cmd)
      CMD_NONE: ;
      CMD_INIT_STEP: begin
        ram_we  = 1'b1;
        ptr_nxt = ptr_r + ADDR_W'(1);
      end
      CMD_LATCH: begin
        ptr_nxt     = '0;
        read_ok_nxt = 1'b0;
      end
      CMD_ERASE_BACK: begin
        if (cur_col_r != '0) cur_col_nxt = cur_col_r - COL_W'(1);
      end
      CMD_CALC_IDX: begin
        idx_nxt = IDX_W'(row_r) * IDX_W'(eff_cols) + IDX_W'(col_src);
      end
      CMD_WRITE_CHAR: begin
        ram_we    = in_range;
        ram_waddr = idx_r[ADDR_W-1:0];
        ram_wdata = {attr_r, item_erase ? CH_SPACE : ch_r};
      end
      CMD_ADVANCE: begin
        cur_col_nxt = cur_col_r + COL_W'(1);
      end
      CMD_NEWLINE: begin
        cur_col_nxt = '0;
        cur_row_nxt = cur_row_r + ROW_W'(1);
      end
      CMD_PTR_CLR: begin
        ptr_nxt = '0;
      end
      CMD_SCROLL_RD: begin
        ram_re = 1'b1;
      end
      CMD_SCROLL_WR: begin
        // Cell one row below, read in the previous cycle, moves up.
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        ptr_nxt   = ptr_r + ADDR_W'(1);
      end
      CMD_ZERO_STEP: begin
        ram_we  = 1'b1;
        ptr_nxt = ptr_r + ADDR_W'(1);
      end
      CMD_LINE_DEC: begin
        cur_row_nxt = cur_row_r - ROW_W'(1);
      end
      CMD_CLEAR_STEP: begin
        ram_we      = 1'b1;
        ram_wdata   = CLEAR_CELL;
        ptr_nxt     = ptr_r + ADDR_W'(1);
        cur_col_nxt = '0;
        cur_row_nxt = '0;
      end
      CMD_SET_CURSOR: begin
        cur_col_nxt = col_r;
        cur_row_nxt = row_r;
      end
      CMD_READ: begin
        ram_re      = in_range;
        ram_raddr   = idx_r[ADDR_W-1:0];
        read_ok_nxt = in_range;
      end
      CMD_RESULT: begin
        out_nxt.cursor_col    = cur_col_r;
        out_nxt.cursor_row    = cur_row_r;
        out_nxt.cursor_linear = LIN_W'(IDX_W'(cur_row_r) * IDX_W'(eff_cols)
                                       + IDX_W'(cur_col_r));
        out_nxt.cell_value    = read_ok_r ? ram_rdata : '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      ptr_r       <= '0;
      read_ok_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_col_r   <= cur_col_nxt;
      cur_row_r   <= cur_row_nxt;
      ptr_r       <= ptr_nxt;
      read_ok_r   <= read_ok_nxt;
      out_valid_r <= cmd == CMD_RESULT;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == CMD_LATCH) begin
      op_r  <= op_t'(in_data.operation);
      ch_r  <= in_data.char_code;
      col_r <= in_data.col;
      row_r <= in_data.row;
    end
    idx_r   <= idx_nxt;
    out_r   <= out_nxt;
    total_r <= ADDR_W'(ADDR_W'(eff_cols) * ADDR_W'(eff_rows));
  end

  tccs_ram #(
    .WIDTH (CELL_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/text_console_cursor_scroll.sv =====
// Text console engine: one result word per accepted word, one word in flight.
// Scrolling and clear screen step through the store one cell at a time, since it has a single
// write port. The next word is taken at the edge that ends the strobe cycle. After reset,
// busy stays high while the store is swept to zero; configuration writes are taken.
module text_console_cursor_scroll
  import tccs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  tccs_in_t              in_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic                  out_valid,
  output tccs_out_t             out_data
);

  cmd_t         cmd;
  tccs_status_t st;

  tccs_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .st    (st),
    .cmd   (cmd),
    .busy  (busy)
  );

  tccs_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .st        (st),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/tccs_checker.sv =====
// Port-level checks for the text console engine, bound to the top level.
// Watches only the handshake ports; no package dependencies.
module tccs_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  // An accepted word keeps the engine occupied until its result is out.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted word did not raise busy");

  // A result appears only once its work is finished.
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while still busy");

  // Each result ends a stretch of work.
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without preceding work");

  // One word in flight: strobes never come in adjacent cycles.
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("two result strobes in a row");

endmodule

bind text_console_cursor_scroll tccs_checker u_tccs_checker (.*);

// ===== tb/sv/tb_text_console_cursor_scroll.sv =====
// Self-checking testbench for the text console engine: directed words, then
// random typing sessions over many screen sizes, checked against a predictor.
// Depends on tccs_pkg and text_console_cursor_scroll.
module tb_text_console_cursor_scroll;
  import tccs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IN_W        = $bits(tccs_in_t);
  localparam int CYCLE_LIMIT = 40000000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  tccs_in_t              in_data = '0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  out_valid;
  tccs_out_t             out_data;

  text_console_cursor_scroll dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow of the console: cell store, cursor and registers.
  logic [CELL_W-1:0] screen_cells [STORE_DEPTH];
  logic [COL_W-1:0]  cur_col;
  logic [ROW_W-1:0]  cur_line;
  logic [ATTR_W-1:0] attr_reg;
  logic [COL_W-1:0]  cols_reg;
  logic [ROW_W-1:0]  rows_reg;

  tccs_out_t cursor_reports[$];

  int unsigned mismatches;
  int unsigned results_checked;
  int unsigned words_sent;
  int unsigned scroll_steps;
  int unsigned cell_reads;
  int unsigned geometries;
  int unsigned burst_left;
  int unsigned cycle_count;

  function automatic int unsigned span_cols();
    if (cols_reg < 1) return 1;
    if (cols_reg > MAX_COLUMNS) return MAX_COLUMNS;
    return cols_reg;
  endfunction

  function automatic int unsigned span_rows();
    if (rows_reg < 2) return 2;
    if (rows_reg > ROWS_LIMIT) return ROWS_LIMIT;
    return rows_reg;
  endfunction

  function automatic void reset_console();
    foreach (screen_cells[i]) screen_cells[i] = '0;
    cur_col  = '0;
    cur_line = '0;
    attr_reg = '0;
    cols_reg = RST_COLS_C;
    rows_reg = RST_ROWS_C;
  endfunction

  function automatic void store_cell(input int unsigned idx, input logic [CELL_W-1:0] value);
    if (idx < span_cols() * span_rows()) screen_cells[idx] = value;
  endfunction

  function automatic void scroll_screen();
    int unsigned c;
    int unsigned last;
    c = span_cols();
    last = c * (span_rows() - 1);
    for (int unsigned i = 0; i < last; i++) screen_cells[i] = screen_cells[i + c];
    for (int unsigned i = 0; i < c; i++) screen_cells[last + i] = '0;
    scroll_steps++;
  endfunction

  // The line wraps at five bits, so a cursor parked far below the screen
  // scrolls repeatedly until it is back on the second-to-last row.
  function automatic void line_feed();
    cur_col  = '0;
    cur_line = cur_line + 1'b1;
    while (cur_line >= span_rows() - 1) begin
      scroll_screen();
      cur_line = cur_line - 1'b1;
    end
  endfunction

  function automatic tccs_out_t console_step(input tccs_in_t w);
    tccs_out_t   report;
    int unsigned c;
    int unsigned idx;
    logic [CELL_W-1:0] cell_word;
    c = span_cols();
    cell_word = '0;
    case (w.operation)
      OP_PUT: begin
        if (w.char_code == CH_NEWLINE) begin
          line_feed();
        end else if (w.char_code == CH_ERASE) begin
          if (cur_col != '0) cur_col = cur_col - 1'b1;
          store_cell(w.row * c + cur_col, {attr_reg, CH_SPACE});
        end else begin
          store_cell(w.row * c + w.col, {attr_reg, w.char_code});
          if (cur_col + 1 >= c) line_feed();
          else cur_col = cur_col + 1'b1;
        end
      end
      OP_CLEAR: begin
        for (int unsigned i = 0; i < c * span_rows(); i++) screen_cells[i] = CLEAR_CELL;
        cur_col  = '0;
        cur_line = '0;
      end
      OP_SET: begin
        cur_col  = w.col;
        cur_line = w.row;
      end
      OP_READ: begin
        idx = w.row * c + w.col;
        if (idx < c * span_rows()) cell_word = screen_cells[idx];
        cell_reads++;
      end
      default: ;
    endcase
    report.cursor_col    = cur_col;
    report.cursor_row    = cur_line;
    report.cursor_linear = LIN_W'(cur_line * c + cur_col);
    report.cell_value    = cell_word;
    return report;
  endfunction

  function automatic tccs_in_t make_word(input op_t op, input logic [CHAR_W-1:0] ch,
                                         input logic [COL_W-1:0] col,
                                         input logic [ROW_W-1:0] row);
    tccs_in_t w;
    w.operation = op;
    w.char_code = ch;
    w.col       = col;
    w.row       = row;
    return w;
  endfunction

  // Mostly typing at the cursor, with line feeds, erases, cursor moves and
  // reads mixed in, plus raw words. Cursor moves far off screen are kept to
  // small screens, where the long scroll runs they cause stay cheap.
  function automatic tccs_in_t random_word();
    tccs_in_t        w;
    logic [IN_W-1:0] raw;
    int unsigned     c;
    int unsigned     r;
    int unsigned     pick;
    logic            wild;
    c = span_cols();
    r = span_rows();
    wild = (c * r <= 256);
    pick = $urandom_range(0, 99);
    w = make_word(OP_PUT, CHAR_W'($urandom_range(0, 255)), cur_col, cur_line);
    if (pick >= 90) begin
      raw = IN_W'($urandom());
      w = raw;
      if (!wild && (w.operation == OP_SET || w.operation == OP_CLEAR)) w.operation = OP_READ;
    end else if (pick >= 88) begin
      if (wild || $urandom_range(0, 3) == 0) w.operation = OP_CLEAR;
    end else if (pick >= 74) begin
      w.operation = OP_READ;
      if ($urandom_range(0, 3) == 0) begin
        w.col = COL_W'($urandom_range(0, 127));
        w.row = ROW_W'($urandom_range(0, 31));
      end else begin
        w.col = COL_W'($urandom_range(0, c - 1));
        w.row = ROW_W'($urandom_range(0, r - 1));
      end
    end else if (pick >= 64) begin
      w.operation = OP_SET;
      if (wild && $urandom_range(0, 3) == 0) begin
        w.col = COL_W'($urandom_range(0, 127));
        w.row = ROW_W'($urandom_range(0, 31));
      end else begin
        w.col = COL_W'($urandom_range(0, c - 1));
        w.row = ROW_W'($urandom_range(0, r - 1));
      end
    end else if (pick >= 58) begin
      w.char_code = CH_ERASE;
    end else if (pick >= 50) begin
      w.char_code = CH_NEWLINE;
    end
    return w;
  endfunction

  // Bursts of back-to-back words separated by random gaps. start stays high
  // inside a burst, so it is lowered only when a gap follows.
  task automatic send_word(input tccs_in_t w);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start   <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (busy !== 1'b0);
    cursor_reports.push_back(console_step(w));
    words_sent++;
  endtask

  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (busy !== 1'b0 || cursor_reports.size() != 0);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      CFG_COLOR:   attr_reg = value;
      CFG_COLUMNS: cols_reg = value[COL_W-1:0];
      CFG_ROWS:    rows_reg = value[ROW_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [7:0] attr, input logic [7:0] cols,
                           input logic [7:0] rows);
    settle();
    write_reg(CFG_COLOR, attr);
    write_reg(CFG_COLUMNS, cols);
    write_reg(CFG_ROWS, rows);
    cfg_we <= 1'b0;
    geometries++;
  endtask

  task automatic test_reset_state();
    send_word(make_word(OP_READ, 8'h00, 7'd79, 5'd24));
  endtask

  task automatic test_put_and_read();
    configure(8'h1E, 8'd80, 8'd25);
    send_word(make_word(OP_PUT, 8'h41, 7'd0, 5'd0));
    send_word(make_word(OP_PUT, 8'h00, 7'd1, 5'd0));
    send_word(make_word(OP_PUT, 8'hFF, 7'd79, 5'd24));
    // Off the screen: the write is dropped but the cursor still advances.
    send_word(make_word(OP_PUT, 8'h55, 7'd127, 5'd31));
    // A column past the row width lands in the next row.
    send_word(make_word(OP_PUT, 8'h2A, 7'd100, 5'd0));
    send_word(make_word(OP_READ, 8'h00, 7'd79, 5'd24));
    send_word(make_word(OP_READ, 8'h00, 7'd20, 5'd1));
    send_word(make_word(OP_READ, 8'h00, 7'd127, 5'd31));
  endtask

  task automatic test_erase();
    send_word(make_word(OP_SET, 8'h00, 7'd1, 5'd3));
    send_word(make_word(OP_PUT, CH_ERASE, 7'd0, 5'd7));
    // Column is already zero, so it stays put and the space goes to column 0.
    send_word(make_word(OP_PUT, CH_ERASE, 7'd0, 5'd3));
    send_word(make_word(OP_READ, 8'h00, 7'd0, 5'd7));
  endtask

  task automatic test_wrap_and_scroll();
    send_word(make_word(OP_SET, 8'h00, 7'd78, 5'd23));
    send_word(make_word(OP_PUT, 8'h5A, 7'd78, 5'd23));
    send_word(make_word(OP_PUT, 8'h59, 7'd79, 5'd23));
    send_word(make_word(OP_READ, 8'h00, 7'd78, 5'd22));
  endtask

  task automatic test_cursor_outside();
    send_word(make_word(OP_SET, 8'h00, 7'd127, 5'd31));
    send_word(make_word(OP_PUT, CH_NEWLINE, 7'd0, 5'd0));
    send_word(make_word(OP_SET, 8'h00, 7'd3, 5'd24));
    send_word(make_word(OP_PUT, CH_NEWLINE, 7'd0, 5'd0));
  endtask

  task automatic test_clear_screen();
    configure(8'hFF, 8'd80, 8'd25);
    send_word(make_word(OP_CLEAR, 8'h00, 7'd0, 5'd0));
    send_word(make_word(OP_READ, 8'h00, 7'd0, 5'd0));
    send_word(make_word(OP_READ, 8'h00, 7'd79, 5'd24));
    send_word(make_word(OP_PUT, 8'h78, 7'd0, 5'd0));
    send_word(make_word(OP_READ, 8'h00, 7'd0, 5'd0));
  endtask

  task automatic test_random_typing(input int unsigned count, input logic [7:0] cols,
                                    input logic [7:0] rows);
    configure(8'($urandom_range(0, 255)), cols, rows);
    repeat (count) send_word(random_word());
  endtask

  always @(posedge clk) begin
    tccs_out_t want;
    if (rst_n && out_valid) begin
      results_checked++;
      if (cursor_reports.size() == 0) begin
        $error("unexpected result word %h", out_data);
        mismatches++;
      end else begin
        want = cursor_reports.pop_front();
        if (out_data.cursor_col !== want.cursor_col) begin
          $error("cursor_col: expected %0d, got %0d", want.cursor_col, out_data.cursor_col);
          mismatches++;
        end
        if (out_data.cursor_row !== want.cursor_row) begin
          $error("cursor_row: expected %0d, got %0d", want.cursor_row, out_data.cursor_row);
          mismatches++;
        end
        if (out_data.cursor_linear !== want.cursor_linear) begin
          $error("cursor_linear: expected %0d, got %0d", want.cursor_linear,
                 out_data.cursor_linear);
          mismatches++;
        end
        if (out_data.cell_value !== want.cell_value) begin
          $error("cell_value: expected %h, got %h", want.cell_value, out_data.cell_value);
          mismatches++;
        end
      end
    end
  end

  initial begin
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
    $display("text_console_cursor_scroll regression: fail");
    $finish;
  end

  initial begin
    reset_console();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_put_and_read();
    test_erase();
    test_wrap_and_scroll();
    test_cursor_outside();
    test_clear_screen();

    // One column: every printable character wraps, and scrolls unless the line number wraps to zero.
    test_random_typing(150, 8'd1, 8'd2);
    // Both sizes below their minimum; the high bits must be ignored too.
    test_random_typing(100, 8'h80, 8'h01);
    test_random_typing(200, 8'd8, 8'd4);
    test_random_typing(200, 8'd16, 8'd6);
    test_random_typing(150, 8'd80, 8'd2);
    test_random_typing(120, 8'd1, 8'd25);
    test_random_typing(150, 8'd40, 8'd12);
    repeat (4) test_random_typing(150, 8'($urandom_range(1, 24)), 8'($urandom_range(2, 8)));
    // Both sizes above their maximum, which leaves the full 80 by 25 screen.
    test_random_typing(150, 8'hFF, 8'hFF);

    settle();
    repeat (16) @(posedge clk);
    $display("Sent %0d words over %0d register settings; %0d result words checked.",
             words_sent, geometries, results_checked);
    $display("The predictor walked %0d scroll steps and %0d cell reads.",
             scroll_steps, cell_reads);
    if (mismatches == 0 && cursor_reports.size() == 0) begin
      $display("text_console_cursor_scroll regression: pass");
    end else begin
      $display("text_console_cursor_scroll regression: fail");
    end
    $finish;
  end

endmodule
